// ===== hw/rtl/video_keyframe_detector_top_assert.svh =====
// assertion macros shared by the keyframe detector rtl
// each use expects clk and arst_n in the enclosing module
`ifndef VIDEO_KEYFRAME_DETECTOR_TOP_ASSERT_SVH
`define VIDEO_KEYFRAME_DETECTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define VKD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define VKD_ASSERT_NEVER(label, expr, msg) \
	`VKD_ASSERT(label, !(expr), msg)
`else
`define VKD_ASSERT(label, prop, msg)
`define VKD_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== hw/rtl/vkd_pkg.sv =====
package vkd_pkg;

	typedef enum logic [1:0] {
		CODEC_H264  = 2'd0,
		CODEC_VP8   = 2'd1,
		CODEC_VP9   = 2'd2,
		CODEC_OTHER = 2'd3
	} codec_t;

	// length-prefix walk phase
	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_HEADER = 2'd1,
		PH_SKIP   = 2'd2
	} phase_t;

	typedef struct packed {
		codec_t     codec;
		logic [2:0] nls;
	} cfg_t;

	// register index taken from paddr[2]
	localparam logic REG_CODEC = 1'b0;
	localparam logic REG_NLS   = 1'b1;

	localparam logic [4:0]  NAL_TYPE_IDR = 5'd5;
	localparam logic [23:0] START_CODE   = 24'h000001;
	localparam logic [23:0] RECENT_INIT  = 24'hFFFFFF;
	localparam logic [2:0]  NLS_MAX      = 3'd4;
	localparam logic [1:0]  VP9_MARKER   = 2'b10;
	localparam logic [1:0]  VP9_PROF3    = 2'b11;

	function automatic logic vp9_key(input logic [7:0] b);
		logic [1:0] profile;
		logic       show_existing;
		logic       frame_type;
		profile = {b[4], b[5]};
		if (profile == VP9_PROF3) begin
			show_existing = b[2];
			frame_type    = b[1];
		end else begin
			show_existing = b[3];
			frame_type    = b[2];
		end
		return (b[7:6] == VP9_MARKER) && !show_existing && !frame_type;
	endfunction

endpackage

// ===== hw/rtl/vkd_regs.sv =====
module vkd_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output vkd_pkg::cfg_t cfg
);
	import vkd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.codec <= CODEC_H264;
			cfg_q.nls   <= 3'd0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CODEC: cfg_q.codec <= codec_t'(pwdata[1:0]);
				REG_NLS:   cfg_q.nls   <= pwdata[2:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CODEC: prdata = {30'd0, cfg_q.codec};
			REG_NLS:   prdata = {29'd0, cfg_q.nls};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/vkd_core.sv =====
`include "video_keyframe_detector_top_assert.svh"

module vkd_core #(
	parameter int PACKET_SIZE_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vkd_pkg::cfg_t               cfg,
	input  logic                        advance,
	input  logic [7:0]                  data_byte,
	input  logic [PACKET_SIZE_BITS-1:0] packet_size,
	input  logic                        last_byte,
	input  logic                        demux_key,
	output logic                        verdict
);
	import vkd_pkg::*;

	localparam int P = PACKET_SIZE_BITS;

	logic [P-1:0]  pos_q, pos_d;
	logic [23:0]   recent_q, recent_d;
	logic          found_q, found_d;
	logic          stopped_q, stopped_d;
	phase_t        phase_q, phase_d;
	logic [31:0]   acc_q, acc_d;
	logic [2:0]    pref_q, pref_d;
	logic [31:0]   skip_q, skip_d;

	logic          in_range;
	logic          is_idr;
	logic [2:0]    nls_eff;
	logic [P:0]    pos_plus_nls;
	logic [32:0]   nal_end;
	logic [31:0]   acc_shift;
	logic [2:0]    pref_inc;

	always_comb begin
		pos_d     = pos_q;
		recent_d  = recent_q;
		found_d   = found_q;
		stopped_d = stopped_q;
		phase_d   = phase_q;
		acc_d     = acc_q;
		pref_d    = pref_q;
		skip_d    = skip_q;

		in_range     = pos_q < packet_size;
		is_idr       = data_byte[4:0] == NAL_TYPE_IDR;
		nls_eff      = (cfg.nls > NLS_MAX) ? NLS_MAX : cfg.nls;
		pos_plus_nls = {1'b0, pos_q} + {{(P-2){1'b0}}, nls_eff};
		acc_shift    = {acc_q[23:0], data_byte};
		pref_inc     = pref_q + 3'd1;
		nal_end      = {{(33-P){1'b0}}, pos_q} + 33'd1 + {1'b0, acc_shift};

		if (in_range) begin
			case (cfg.codec)
				CODEC_H264: begin
					if (nls_eff == 3'd0) begin
						// annex-b: idr header right after a start code
						if (recent_q == START_CODE && is_idr)
							found_d = 1'b1;
					end else if (!stopped_q && !found_q) begin
						unique case (phase_q)
							PH_HEADER: begin
								if (is_idr) begin
									found_d   = 1'b1;
									stopped_d = 1'b1;
								end else begin
									phase_d = (skip_q != 32'd0) ? PH_SKIP : PH_PREFIX;
								end
							end
							PH_SKIP: begin
								skip_d = skip_q - 32'd1;
								if (skip_d == 32'd0)
									phase_d = PH_PREFIX;
							end
							default: begin
								phase_d = PH_PREFIX;
								if (pref_q == 3'd0 && pos_plus_nls > {1'b0, packet_size}) begin
									stopped_d = 1'b1;
								end else begin
									acc_d  = acc_shift;
									pref_d = pref_inc;
									if (pref_inc >= nls_eff) begin
										pref_d = 3'd0;
										acc_d  = 32'd0;
										if (acc_shift == 32'd0 ||
											nal_end > {{(33-P){1'b0}}, packet_size}) begin
											stopped_d = 1'b1;
										end else begin
											skip_d  = acc_shift - 32'd1;
											phase_d = PH_HEADER;
										end
									end
								end
							end
						endcase
					end
				end
				CODEC_VP8: begin
					if (pos_q == '0)
						found_d = ~data_byte[0];
				end
				CODEC_VP9: begin
					if (pos_q == '0)
						found_d = vp9_key(data_byte);
				end
				CODEC_OTHER: ;
				default: ;
			endcase
			recent_d = {recent_q[15:0], data_byte};
		end

		pos_d = (&pos_q) ? pos_q : pos_q + {{(P-1){1'b0}}, 1'b1};

		verdict = (cfg.codec == CODEC_OTHER) ? demux_key : found_d;

		if (last_byte) begin
			pos_d     = '0;
			recent_d  = RECENT_INIT;
			found_d   = 1'b0;
			stopped_d = 1'b0;
			phase_d   = PH_PREFIX;
			acc_d     = 32'd0;
			pref_d    = 3'd0;
			skip_d    = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			recent_q  <= RECENT_INIT;
			found_q   <= 1'b0;
			stopped_q <= 1'b0;
			phase_q   <= PH_PREFIX;
			acc_q     <= 32'd0;
			pref_q    <= 3'd0;
			skip_q    <= 32'd0;
		end else if (advance) begin
			pos_q     <= pos_d;
			recent_q  <= recent_d;
			found_q   <= found_d;
			stopped_q <= stopped_d;
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			pref_q    <= pref_d;
			skip_q    <= skip_d;
		end
	end

	`VKD_ASSERT(a_prefix_no_skip, phase_q == PH_PREFIX |-> skip_q == 32'd0, "skip left in prefix phase")
	`VKD_ASSERT(a_prefix_clear, phase_q != PH_PREFIX |-> pref_q == 3'd0 && acc_q == 32'd0, "prefix state left outside prefix phase")
	`VKD_ASSERT(a_packet_clear, advance && last_byte |=> pos_q == '0 && !found_q && !stopped_q && phase_q == PH_PREFIX, "packet state not cleared")

endmodule

// ===== hw/rtl/video_keyframe_detector_top.sv =====
// channel   dir  transaction                  fields (tdata/tuser from bit 0 up)
// s_axis    in   one packet byte              tdata: data_byte, packet_size; tlast: last_byte;
//                                             tuser: demux_key
// m_axis    out  one verdict per packet       tdata: is_key_frame
// apb       in   register write/read          0x0 codec_select, 0x4 nal_length_size
//
// one byte per cycle bar the stall below: bytes enter an input register, one pass of
// compare and counter logic updates the walk state; the verdict lands in a result register
// the slowest path is the 33-bit nal end add and compare in the length-prefix walk
// reset (arst_n low) clears control state and selects h.264 annex-b
// a waiting verdict only stalls the input when the next byte to finish is also a last byte
`include "video_keyframe_detector_top_assert.svh"

module video_keyframe_detector_top #(
	parameter int PACKET_SIZE_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,

	// byte stream in
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [((8+PACKET_SIZE_BITS+7)/8)*8-1:0] s_axis_tdata, // data_byte, packet_size, pad
	input  logic                s_axis_tlast,  // last_byte
	input  logic                s_axis_tuser,  // demux_key

	// verdict out
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,  // is_key_frame, pad

	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import vkd_pkg::*;

	localparam int P = PACKET_SIZE_BITS;

	cfg_t         cfg;

	// input register stage
	logic         valid_s1;
	logic [7:0]   data_s1;
	logic [P-1:0] size_s1;
	logic         last_s1;
	logic         key_s1;

	// result register
	logic         out_valid_q;
	logic         out_key_q;

	logic         advance;
	logic         verdict;

	// hold the byte only when it would finish a packet onto a verdict not yet taken
	assign advance       = valid_s1 && !(last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata[7:0];
			size_s1 <= s_axis_tdata[8 +: P];
			last_s1 <= s_axis_tlast;
			key_s1  <= s_axis_tuser;
		end
	end

	vkd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vkd_core #(
		.PACKET_SIZE_BITS (P)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.advance     (advance),
		.data_byte   (data_s1),
		.packet_size (size_s1),
		.last_byte   (last_s1),
		.demux_key   (key_s1),
		.verdict     (verdict)
	);

	// verdict register, loaded on the packet's last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && last_s1)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			out_key_q <= verdict;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_key_q};

	`VKD_ASSERT(a_last_gives_result, advance && last_s1 |=> out_valid_q, "packet end gave no verdict")
	`VKD_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(advance && last_s1), "verdict without packet end")
	`VKD_ASSERT_NEVER(a_no_overwrite, advance && last_s1 && out_valid_q && !m_axis_tready, "pending verdict overwritten")

endmodule
